// File: rtl/core/lav_pkg.sv
// lav_pkg: shared widths, stage carry type and rounding helper for the look-at block
// no dependencies; used by every module under rtl/core
package lav_pkg;

  localparam int FRAC        = 16;                 // fraction bits of the fixed-point format
  localparam int WORD_W      = 32;                 // input words and translations
  localparam int COMP_W      = FRAC + 2;           // basis components, |c| <= 1.0
  localparam int CR_W        = WORD_W + COMP_W;    // products and cross results
  localparam int DOT_W       = CR_W + 2;           // three-term dot products
  localparam int NORM_HI_BIT = 29;                 // top bit of the scaled largest magnitude
  localparam int MAG_W       = NORM_HI_BIT + 1;
  localparam int SUM_W       = 2 * MAG_W + 2;      // sum of three squares
  localparam int SQ_STEPS    = SUM_W / 2;          // one result bit per sqrt stage
  localparam int LEN_W       = MAG_W + 1;
  localparam int Q_W         = FRAC + 1;           // quotient bits, up to 1.0
  localparam int REM_W       = LEN_W + FRAC + 1;
  localparam int SH_W        = $clog2(CR_W);
  localparam int SIDE_W      = 3 * WORD_W + 6 * COMP_W;
  localparam int IN_W        = 9 * WORD_W;
  localparam int OUT_BITS    = 3 * (3 * COMP_W + WORD_W);
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [DOT_W-1:0] HALF_D  = DOT_W'(1) << (FRAC - 1);
  localparam logic [DOT_W-1:0] ONE_D   = DOT_W'(1) << FRAC;
  localparam logic [Q_W-1:0]   ONE_Q   = Q_W'(1) << FRAC;
  localparam logic [DOT_W-1:0] SAT_MAX = DOT_W'((64'(1) << (WORD_W - 1)) - 64'(1));

  // payload that travels along the normalize stages after scaling
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
    logic [SIDE_W-1:0]     side;
  } norm_carry_t;

  // round(x / 2^FRAC), ties away from zero
  function automatic logic [DOT_W-1:0] rnd_frac(input logic [DOT_W-1:0] x);
    logic [DOT_W-1:0] m;
    m = x[DOT_W-1] ? -x : x;
    m = (m + HALF_D) >> FRAC;
    return x[DOT_W-1] ? -m : m;
  endfunction

endpackage

// File: rtl/core/lav_norm.sv
// lav_norm: pipelined normalize of a 3-vector (scale, squares, sqrt, three dividers)
// depends on lav_pkg
module lav_norm (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [2:0][lav_pkg::CR_W-1:0]            in_vec,
  input  logic [lav_pkg::SIDE_W-1:0]               in_side,
  output logic                                     out_valid,
  output logic [2:0][lav_pkg::COMP_W-1:0]          out_vec,
  output logic [lav_pkg::SIDE_W-1:0]               out_side
);

  // stage 1: magnitudes and largest magnitude
  logic [2:0][lav_pkg::CR_W-1:0] mag1_next;
  logic [lav_pkg::CR_W-1:0]      mx1_next;
  logic                          s1_valid;
  logic [2:0][lav_pkg::CR_W-1:0] s1_mag;
  logic [2:0]                    s1_neg;
  logic [lav_pkg::CR_W-1:0]      s1_mx;
  logic [lav_pkg::SIDE_W-1:0]    s1_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_next[i] = in_vec[i][lav_pkg::CR_W-1] ? -in_vec[i] : in_vec[i];
    end
    mx1_next = mag1_next[0];
    if (mag1_next[1] > mx1_next) mx1_next = mag1_next[1];
    if (mag1_next[2] > mx1_next) mx1_next = mag1_next[2];
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= in_valid;
    if (en) begin
      s1_mag  <= mag1_next;
      s1_mx   <= mx1_next;
      s1_side <= in_side;
      for (int i = 0; i < 3; i++) s1_neg[i] <= in_vec[i][lav_pkg::CR_W-1];
    end
  end

  // stage 2: leading-one position and scaling shift
  logic [lav_pkg::SH_W-1:0]      pos2;
  logic                          s2_valid;
  logic [2:0][lav_pkg::CR_W-1:0] s2_mag;
  logic [2:0]                    s2_neg;
  logic [lav_pkg::SIDE_W-1:0]    s2_side;
  logic                          s2_right;
  logic [lav_pkg::SH_W-1:0]      s2_sh;
  logic                          s2_zero;

  always_comb begin
    pos2 = '0;
    for (int i = 0; i < lav_pkg::CR_W; i++) begin
      if (s1_mx[i]) pos2 = lav_pkg::SH_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) begin
      s2_mag   <= s1_mag;
      s2_neg   <= s1_neg;
      s2_side  <= s1_side;
      s2_zero  <= (s1_mx == '0);
      s2_right <= (pos2 >= lav_pkg::SH_W'(lav_pkg::NORM_HI_BIT));
      s2_sh    <= (pos2 >= lav_pkg::SH_W'(lav_pkg::NORM_HI_BIT)) ?
                  pos2 - lav_pkg::SH_W'(lav_pkg::NORM_HI_BIT) :
                  lav_pkg::SH_W'(lav_pkg::NORM_HI_BIT) - pos2;
    end
  end

  // stage 3: apply the shift
  lav_pkg::norm_carry_t          c3_next;
  logic [2:0][lav_pkg::CR_W-1:0] shifted3;
  logic                          s3_valid;
  lav_pkg::norm_carry_t          s3_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted3[i]   = s2_right ? (s2_mag[i] >> s2_sh) : (s2_mag[i] << s2_sh);
      c3_next.mag[i] = shifted3[i][lav_pkg::MAG_W-1:0];
    end
    c3_next.neg  = s2_neg;
    c3_next.zero = s2_zero;
    c3_next.side = s2_side;
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
    if (en) s3_c <= c3_next;
  end

  // stage 4: squares
  logic                             s4_valid;
  lav_pkg::norm_carry_t             s4_c;
  logic [2:0][2*lav_pkg::MAG_W-1:0] s4_sq;

  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (en) s4_valid <= s3_valid;
    if (en) begin
      s4_c <= s3_c;
      for (int i = 0; i < 3; i++) s4_sq[i] <= s3_c.mag[i] * s3_c.mag[i];
    end
  end

  // stage 5: sum of squares, then one sqrt bit per stage
  logic                       sq_v [0:lav_pkg::SQ_STEPS];
  lav_pkg::norm_carry_t       sq_c [0:lav_pkg::SQ_STEPS];
  logic [lav_pkg::SUM_W-1:0]  sq_n [0:lav_pkg::SQ_STEPS];
  logic [lav_pkg::SUM_W-1:0]  sq_r [0:lav_pkg::SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= s4_valid;
    if (en) begin
      sq_c[0] <= s4_c;
      sq_r[0] <= '0;
      sq_n[0] <= lav_pkg::SUM_W'(s4_sq[0]) + lav_pkg::SUM_W'(s4_sq[1])
               + lav_pkg::SUM_W'(s4_sq[2]);
    end
  end

  for (genvar k = 0; k < lav_pkg::SQ_STEPS; k++) begin : g_sqrt
    logic [lav_pkg::SUM_W-1:0] bitv;
    logic [lav_pkg::SUM_W:0]   trial;
    logic                      ge;
    assign bitv  = lav_pkg::SUM_W'(1) << (2 * (lav_pkg::SQ_STEPS - 1 - k));
    assign trial = {1'b0, sq_r[k]} + {1'b0, bitv};
    assign ge    = ({1'b0, sq_n[k]} >= trial);
    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (en) sq_v[k+1] <= sq_v[k];
      if (en) begin
        sq_c[k+1] <= sq_c[k];
        sq_n[k+1] <= ge ? sq_n[k] - trial[lav_pkg::SUM_W-1:0] : sq_n[k];
        sq_r[k+1] <= ge ? (sq_r[k] >> 1) + bitv : (sq_r[k] >> 1);
      end
    end
  end

  // divider set-up: dividend is mag * 2^FRAC + len / 2
  logic                              dv_v   [0:lav_pkg::Q_W];
  lav_pkg::norm_carry_t              dv_c   [0:lav_pkg::Q_W];
  logic [lav_pkg::LEN_W-1:0]         dv_len [0:lav_pkg::Q_W];
  logic [2:0][lav_pkg::REM_W-1:0]    dv_rem [0:lav_pkg::Q_W];
  logic [2:0][lav_pkg::Q_W-1:0]      dv_q   [0:lav_pkg::Q_W];
  logic [lav_pkg::LEN_W-1:0]         len0;

  assign len0 = sq_r[lav_pkg::SQ_STEPS][lav_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= sq_v[lav_pkg::SQ_STEPS];
    if (en) begin
      dv_c[0]   <= sq_c[lav_pkg::SQ_STEPS];
      dv_len[0] <= len0;
      dv_q[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (lav_pkg::REM_W'(sq_c[lav_pkg::SQ_STEPS].mag[i]) << lav_pkg::FRAC)
                      + lav_pkg::REM_W'(len0 >> 1);
      end
    end
  end

  // restoring division, one quotient bit per stage for all three components
  for (genvar j = 0; j < lav_pkg::Q_W; j++) begin : g_div
    logic [lav_pkg::REM_W-1:0] trial;
    logic [lav_pkg::Q_W-1:0]   qbit;
    assign trial = lav_pkg::REM_W'(dv_len[j]) << (lav_pkg::Q_W - 1 - j);
    assign qbit  = lav_pkg::Q_W'(1) << (lav_pkg::Q_W - 1 - j);
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (en) dv_v[j+1] <= dv_v[j];
      if (en) begin
        dv_c[j+1]   <= dv_c[j];
        dv_len[j+1] <= dv_len[j];
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= trial) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - trial;
            dv_q[j+1][i]   <= dv_q[j][i] | qbit;
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
      end
    end
  end

  // clamp, sign, zero vector
  logic [2:0][lav_pkg::Q_W-1:0] qc;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[lav_pkg::Q_W][i] > lav_pkg::ONE_Q) ? lav_pkg::ONE_Q
                                                          : dv_q[lav_pkg::Q_W][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_v[lav_pkg::Q_W];
    if (en) begin
      out_side <= dv_c[lav_pkg::Q_W].side;
      for (int i = 0; i < 3; i++) begin
        if (dv_c[lav_pkg::Q_W].zero) out_vec[i] <= '0;
        else if (dv_c[lav_pkg::Q_W].neg[i]) out_vec[i] <= -lav_pkg::COMP_W'(qc[i]);
        else out_vec[i] <= lav_pkg::COMP_W'(qc[i]);
      end
    end
  end

endmodule

// File: rtl/core/lav_cross.sv
// lav_cross: two-stage cross product a x b (products, then differences)
// depends on lav_pkg
module lav_cross (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [2:0][lav_pkg::WORD_W-1:0]    a,
  input  logic [2:0][lav_pkg::COMP_W-1:0]    b,
  input  logic [lav_pkg::SIDE_W-1:0]         in_side,
  output logic                               out_valid,
  output logic [2:0][lav_pkg::CR_W-1:0]      out_vec,
  output logic [lav_pkg::SIDE_W-1:0]         out_side
);

  logic                               p_valid;
  logic [lav_pkg::SIDE_W-1:0]         p_side;
  logic signed [lav_pkg::CR_W-1:0]    p12, p21, p20, p02, p01, p10;

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= in_valid;
    if (en) begin
      p_side <= in_side;
      p12 <= $signed(a[1]) * $signed(b[2]);
      p21 <= $signed(a[2]) * $signed(b[1]);
      p20 <= $signed(a[2]) * $signed(b[0]);
      p02 <= $signed(a[0]) * $signed(b[2]);
      p01 <= $signed(a[0]) * $signed(b[1]);
      p10 <= $signed(a[1]) * $signed(b[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= p_valid;
    if (en) begin
      out_side   <= p_side;
      out_vec[0] <= p12 - p21;
      out_vec[1] <= p20 - p02;
      out_vec[2] <= p01 - p10;
    end
  end

endmodule

// File: rtl/core/lav_tail.sv
// lav_tail: rounds the upward axis, forms the three translations, output register
// depends on lav_pkg
module lav_tail (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [2:0][lav_pkg::CR_W-1:0]           v_raw,
  input  logic [2:0][lav_pkg::WORD_W-1:0]         eye,
  input  logic [2:0][lav_pkg::COMP_W-1:0]         u,
  input  logic [2:0][lav_pkg::COMP_W-1:0]         w,
  output logic                                    out_valid,
  output logic [2:0][2:0][lav_pkg::COMP_W-1:0]    out_axes,
  output logic [2:0][lav_pkg::WORD_W-1:0]         out_shift
);

  function automatic logic [lav_pkg::DOT_W-1:0] lav_lib_round(
      input logic [lav_pkg::CR_W-1:0] x);
    return lav_pkg::rnd_frac(lav_pkg::DOT_W'($signed(x)));
  endfunction

  // t1: round and clamp v; rows are right, upward, back
  logic [2:0][lav_pkg::DOT_W-1:0]          vr;
  logic [2:0][lav_pkg::COMP_W-1:0]         vc;
  logic                                    t1_valid;
  logic [2:0][2:0][lav_pkg::COMP_W-1:0]    t1_axes;
  logic [2:0][lav_pkg::WORD_W-1:0]         t1_eye;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vr[i] = lav_lib_round(v_raw[i]);
      if ($signed(vr[i]) > $signed(lav_pkg::ONE_D)) vc[i] = lav_pkg::COMP_W'(lav_pkg::ONE_D);
      else if ($signed(vr[i]) < -$signed(lav_pkg::ONE_D))
        vc[i] = lav_pkg::COMP_W'(-lav_pkg::ONE_D);
      else vc[i] = vr[i][lav_pkg::COMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) t1_valid <= 1'b0;
    else if (en) t1_valid <= in_valid;
    if (en) begin
      t1_axes[0] <= u;
      t1_axes[1] <= vc;
      t1_axes[2] <= w;
      t1_eye     <= eye;
    end
  end

  // t2: nine products
  logic                                    t2_valid;
  logic [2:0][2:0][lav_pkg::COMP_W-1:0]    t2_axes;
  logic [2:0][2:0][lav_pkg::CR_W-1:0]      t2_prod;

  always_ff @(posedge clk) begin
    if (rst) t2_valid <= 1'b0;
    else if (en) t2_valid <= t1_valid;
    if (en) begin
      t2_axes <= t1_axes;
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          t2_prod[r][i] <= lav_pkg::CR_W'($signed(t1_axes[r][i]) * $signed(t1_eye[i]));
        end
      end
    end
  end

  // t3: dot sums
  logic                                    t3_valid;
  logic [2:0][2:0][lav_pkg::COMP_W-1:0]    t3_axes;
  logic [2:0][lav_pkg::DOT_W-1:0]          t3_dot;

  always_ff @(posedge clk) begin
    if (rst) t3_valid <= 1'b0;
    else if (en) t3_valid <= t2_valid;
    if (en) begin
      t3_axes <= t2_axes;
      for (int r = 0; r < 3; r++) begin
        t3_dot[r] <= lav_pkg::DOT_W'($signed(t2_prod[r][0]))
                   + lav_pkg::DOT_W'($signed(t2_prod[r][1]))
                   + lav_pkg::DOT_W'($signed(t2_prod[r][2]));
      end
    end
  end

  // t4: round, negate, saturate into the output register
  logic [2:0][lav_pkg::DOT_W-1:0] neg4;
  logic [2:0][lav_pkg::WORD_W-1:0] sat4;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      neg4[r] = -lav_pkg::rnd_frac(t3_dot[r]);
      if ($signed(neg4[r]) > $signed(lav_pkg::SAT_MAX))
        sat4[r] = lav_pkg::SAT_MAX[lav_pkg::WORD_W-1:0];
      else if ($signed(neg4[r]) < -$signed(lav_pkg::SAT_MAX) - 1)
        sat4[r] = {1'b1, {(lav_pkg::WORD_W-1){1'b0}}};
      else sat4[r] = neg4[r][lav_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= t3_valid;
    if (en) begin
      out_axes  <= t3_axes;
      out_shift <= sat4;
    end
  end

endmodule

// File: rtl/core/look_at_view_matrix.sv
// look_at_view_matrix: top level of the fixed-point look-at view matrix pipeline
// depends on lav_pkg, lav_norm, lav_cross, lav_tail
//
// takes one camera setup (eye, center, up; signed Q16.16) per item and returns the upper
// three rows of the look-at view matrix: right (u), upward (v) and back (w) axes, each
// with its translation -dot(axis, eye), rounded half away from zero and saturated to
// 32 bits. a zero-length vector normalizes to zero. the block is a single stalling
// pipeline: one item may enter every cycle while the output is not stalled; its stages are an
// input difference stage, two normalize units of 55 stages each, mostly the 31-stage
// square root and the 17-stage dividers, two cross-product stages twice and four output
// stages. all stages advance together whenever the output register is empty or being
// taken, so a stalled output never loses or repeats an item.
module look_at_view_matrix (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z (32 bits each)
  input  logic [lav_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // right_x, right_y, right_z, right_shift, upward_x, upward_y, upward_z, upward_shift,
  // back_x, back_y, back_z, back_shift (components 18 bits, shifts 32), zero fill on top
  output logic [lav_pkg::OUT_W-1:0]    m_axis_tdata
);

  localparam int W = lav_pkg::WORD_W;
  localparam int C = lav_pkg::COMP_W;

  // global advance: the output register is free or being taken
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  logic [2:0][W-1:0] eye_in, ctr_in, up_in;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_in[i] = s_axis_tdata[i*W +: W];
      ctr_in[i] = s_axis_tdata[(3+i)*W +: W];
      up_in[i]  = s_axis_tdata[(6+i)*W +: W];
    end
  end

  // side bus: eye in the low words, then up, or back and right axes
  logic                              a_valid;
  logic [2:0][lav_pkg::CR_W-1:0]     a_diff;
  logic [lav_pkg::SIDE_W-1:0]        a_side;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= s_axis_tvalid && s_axis_tready;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_diff[i] <= lav_pkg::CR_W'($signed(eye_in[i])) - lav_pkg::CR_W'($signed(ctr_in[i]));
      end
      a_side <= {lav_pkg::SIDE_W'(up_in) << (3*W)} | lav_pkg::SIDE_W'(eye_in);
    end
  end

  // back axis w = normalize(eye - center)
  logic                          n1_valid;
  logic [2:0][C-1:0]             w1;
  logic [lav_pkg::SIDE_W-1:0]    n1_side;

  lav_norm u_norm_back (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(a_valid), .in_vec(a_diff), .in_side(a_side),
    .out_valid(n1_valid), .out_vec(w1), .out_side(n1_side)
  );

  // cross(up, w); keep eye and w alongside
  logic [lav_pkg::SIDE_W-1:0]    c1_in_side;
  logic                          c1_valid;
  logic [2:0][lav_pkg::CR_W-1:0] c1_vec;
  logic [lav_pkg::SIDE_W-1:0]    c1_side;

  assign c1_in_side = (lav_pkg::SIDE_W'(w1) << (3*W)) | lav_pkg::SIDE_W'(n1_side[3*W-1:0]);

  lav_cross u_cross_right (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(n1_valid), .a(n1_side[3*W +: 3*W]), .b(w1), .in_side(c1_in_side),
    .out_valid(c1_valid), .out_vec(c1_vec), .out_side(c1_side)
  );

  // right axis u = normalize(cross(up, w))
  logic                          n2_valid;
  logic [2:0][C-1:0]             u2;
  logic [lav_pkg::SIDE_W-1:0]    n2_side;

  lav_norm u_norm_right (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c1_valid), .in_vec(c1_vec), .in_side(c1_side),
    .out_valid(n2_valid), .out_vec(u2), .out_side(n2_side)
  );

  // cross(w, u); w widened to word size, u added to the side bus
  logic [2:0][W-1:0]             w2_wide;
  logic [lav_pkg::SIDE_W-1:0]    c2_in_side;
  logic                          c2_valid;
  logic [2:0][lav_pkg::CR_W-1:0] c2_vec;
  logic [lav_pkg::SIDE_W-1:0]    c2_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w2_wide[i] = W'($signed(n2_side[3*W + i*C +: C]));
    end
  end

  assign c2_in_side = n2_side | (lav_pkg::SIDE_W'(u2) << (3*W + 3*C));

  lav_cross u_cross_upward (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(n2_valid), .a(w2_wide), .b(u2), .in_side(c2_in_side),
    .out_valid(c2_valid), .out_vec(c2_vec), .out_side(c2_side)
  );

  // upward axis, translations, output register
  logic [2:0][2:0][C-1:0]        axes;
  logic [2:0][W-1:0]             shifts;

  lav_tail u_tail (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c2_valid), .v_raw(c2_vec),
    .eye(c2_side[3*W-1:0]),
    .u(c2_side[3*W + 3*C +: 3*C]),
    .w(c2_side[3*W +: 3*C]),
    .out_valid(m_axis_tvalid), .out_axes(axes), .out_shift(shifts)
  );

  assign m_axis_tdata = {{(lav_pkg::OUT_W - lav_pkg::OUT_BITS){1'b0}},
                         shifts[2], axes[2][2], axes[2][1], axes[2][0],
                         shifts[1], axes[1][2], axes[1][1], axes[1][0],
                         shifts[0], axes[0][2], axes[0][1], axes[0][0]};

  // checks on the output item
  logic right_zero, back_zero, upward_zero;
  assign right_zero  = (axes[0] == '0);
  assign upward_zero = (axes[1] == '0);
  assign back_zero   = (axes[2] == '0);

  a_back_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(axes[2][0]) <= $signed(C'(lav_pkg::ONE_D)))
                   && ($signed(axes[2][0]) >= -$signed(C'(lav_pkg::ONE_D))))
    else $error("back_x out of unit range");

  a_right_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && right_zero) |-> (upward_zero && shifts[0] == '0 && shifts[1] == '0))
    else $error("zero right axis with nonzero upward row");

  a_back_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && back_zero) |-> (right_zero && shifts[2] == '0))
    else $error("zero back axis with nonzero dependent row");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> !s_axis_tready || m_axis_tready)
    else $error("input taken while output stalled");

endmodule

// File: tb/tb_look_at_view_matrix.sv
// tb_look_at_view_matrix: self-checking testbench for the look-at view matrix pipeline
// depends on lav_pkg and look_at_view_matrix; a directed table runs first, then random
// camera setups in bursts, all checked in order against typed results or a fixed-point predictor
`timescale 1ns / 1ps

module tb_look_at_view_matrix;
  import lav_pkg::*;

  localparam int ROW_W      = 3 * COMP_W + WORD_W;  // one matrix row in the result
  localparam int HOLD_LEN   = 600;                  // long receiver hold-off
  localparam int IDLE_LIMIT = 5000;                 // watchdog, cycles with no item moving
  localparam int N_RANDOM   = 600;
  localparam int DRAIN_WAIT = 200;

  typedef logic [8:0][WORD_W-1:0] cam_t;            // eye xyz, center xyz, up xyz
  typedef logic [OUT_W-1:0]       mat_t;
  typedef logic [2:0][63:0]       vec3_t;

  typedef struct {
    cam_t cam;
    bit   typed;
    mat_t mat;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  mat_t matrix_q[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;
  int   rx_cycle = 0;

  always #2 clk = ~clk;

  look_at_view_matrix u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // ---------------- predictor ----------------

  // round(x / 2^FRAC), ties away from zero
  function automatic longint round_frac(longint x);
    longint unsigned m;
    m = (x < 0) ? -x : x;
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // scale so the largest magnitude sits in [2^29, 2^30), then divide by the length
  function automatic vec3_t unit_vec(vec3_t a);
    longint unsigned mag[3];
    bit              ng[3];
    longint unsigned mx, sum, len, q;
    vec3_t           r;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = a[i][63];
      mag[i] = ng[i] ? -a[i] : a[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return '0;
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + (len >> 1)) / len;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      r[i] = ng[i] ? -q : q;
    end
    return r;
  endfunction

  function automatic vec3_t cross_of(vec3_t a, vec3_t b);
    longint ax, ay, az, bx, by, bz;
    vec3_t  r;
    ax = a[0]; ay = a[1]; az = a[2];
    bx = b[0]; by = b[1]; bz = b[2];
    r[0] = ay * bz - az * by;
    r[1] = az * bx - ax * bz;
    r[2] = ax * by - ay * bx;
    return r;
  endfunction

  // -dot(axis, eye), rounded and saturated to 32 bits
  function automatic logic [31:0] shift_of(vec3_t axis, vec3_t eye);
    longint d, t;
    d = longint'(axis[0]) * longint'(eye[0]) + longint'(axis[1]) * longint'(eye[1])
      + longint'(axis[2]) * longint'(eye[2]);
    t = -round_frac(d);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic mat_t view_matrix(cam_t c);
    vec3_t  eye, diff, upv, w, u, v, tmp;
    longint e, t;
    mat_t   m;
    for (int i = 0; i < 3; i++) begin
      e = longint'($signed(c[i]));
      eye[i] = e;
      diff[i] = e - longint'($signed(c[3 + i]));
      upv[i] = longint'($signed(c[6 + i]));
    end
    w = unit_vec(diff);
    u = unit_vec(cross_of(upv, w));
    tmp = cross_of(w, u);
    for (int i = 0; i < 3; i++) begin
      t = round_frac(longint'(tmp[i]));
      if (t > (64'sd1 <<< FRAC)) t = 64'sd1 <<< FRAC;
      if (t < -(64'sd1 <<< FRAC)) t = -(64'sd1 <<< FRAC);
      v[i] = t;
    end
    m = '0;
    for (int i = 0; i < 3; i++) begin
      m[i * COMP_W +: COMP_W]             = u[i][COMP_W-1:0];
      m[ROW_W + i * COMP_W +: COMP_W]     = v[i][COMP_W-1:0];
      m[2 * ROW_W + i * COMP_W +: COMP_W] = w[i][COMP_W-1:0];
    end
    m[3 * COMP_W +: WORD_W]             = shift_of(u, eye);
    m[ROW_W + 3 * COMP_W +: WORD_W]     = shift_of(v, eye);
    m[2 * ROW_W + 3 * COMP_W +: WORD_W] = shift_of(w, eye);
    return m;
  endfunction

  // ---------------- table helpers ----------------

  function automatic cam_t cam_of(int ex, int ey, int ez, int cx, int cy, int cz,
                                  int ux, int uy, int uz);
    cam_t c;
    c[0] = ex; c[1] = ey; c[2] = ez;
    c[3] = cx; c[4] = cy; c[5] = cz;
    c[6] = ux; c[7] = uy; c[8] = uz;
    return c;
  endfunction

  // rows given as right, upward, back; each x, y, z, shift
  function automatic mat_t mat_of(int rx, int ry, int rz, int rs, int vx, int vy, int vz,
                                  int vs, int bx, int by, int bz, int bs);
    mat_t m;
    m = '0;
    m[0 +: ROW_W]         = {rs, rz[COMP_W-1:0], ry[COMP_W-1:0], rx[COMP_W-1:0]};
    m[ROW_W +: ROW_W]     = {vs, vz[COMP_W-1:0], vy[COMP_W-1:0], vx[COMP_W-1:0]};
    m[2 * ROW_W +: ROW_W] = {bs, bz[COMP_W-1:0], by[COMP_W-1:0], bx[COMP_W-1:0]};
    return m;
  endfunction

  function automatic int small_val();
    return int'({{11{1'b0}}, 21'($urandom)}) - (1 << 20);
  endfunction

  // three in ten setups are small-valued cameras, the rest full-range noise, extremes and degenerate cases
  function automatic cam_t random_cam();
    cam_t c;
    int   k;
    for (int i = 0; i < 9; i++) c[i] = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5: for (int i = 0; i < 9; i++) c[i] = small_val();
      6: begin
        for (int i = 0; i < 9; i++) c[i] = small_val();
        for (int i = 0; i < 3; i++) c[3 + i] = c[i];
      end
      7: begin
        k = $urandom_range(1, 64) - 32;
        for (int i = 0; i < 6; i++) c[i] = small_val();
        for (int i = 0; i < 3; i++) c[6 + i] = k * (int'(c[i]) - int'(c[3 + i]));
      end
      default: begin
        for (int i = 0; i < 9; i++)
          if ($urandom_range(0, 2) == 0)
            c[i] = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      end
    endcase
    return c;
  endfunction

  // ---------------- sender ----------------

  task automatic send_item(cam_t c, mat_t m);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    matrix_q.push_back(m);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    row_t dir_tab[$];
    cam_t c;
    int   burst;
    dir_tab.push_back('{cam_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    // eye equal to center: everything zero
    dir_tab.push_back('{cam_of(12345, -777, 99, 12345, -777, 99, 0, 65536, 0), 1'b1,
                        mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
    // axis-aligned camera on +z looking at the origin
    dir_tab.push_back('{cam_of(0, 0, 65536, 0, 0, 0, 0, 65536, 0), 1'b1,
                        mat_of(65536, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 65536, -65536)});
    // up parallel to the view direction: right and upward vanish
    dir_tab.push_back('{cam_of(0, 0, 65536, 0, 0, 0, 0, 0, 65536), 1'b1,
                        mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65536, -65536)});
    // zero up vector
    dir_tab.push_back('{cam_of(0, 0, 65536, 0, 0, 0, 0, 0, 0), 1'b1,
                        mat_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65536, -65536)});
    // field extremes, saturating translations and tiny differences
    dir_tab.push_back('{cam_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 0, 65536, 0), 1'b0, '0});
    dir_tab.push_back('{cam_of(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'h7fff_ffff), 1'b0, '0});
    dir_tab.push_back('{cam_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0,
                        32'h8000_0000, 32'h7fff_ffff, 0), 1'b0, '0});
    dir_tab.push_back('{cam_of(-1, -1, -1, 0, 0, 0, -1, 0, 1), 1'b0, '0});
    dir_tab.push_back('{cam_of(1, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0});
    dir_tab.push_back('{cam_of(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0,
                        32'h8000_0000), 1'b0, '0});
    dir_tab.push_back('{cam_of(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0});
    dir_tab.push_back('{cam_of(655360, 327680, -196608, 65536, 0, 0, 0, 65536, 0),
                        1'b0, '0});
    dir_tab.push_back('{cam_of(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                        32'h5555_5555), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].cam, dir_tab[i].typed ? dir_tab[i].mat
                                                 : view_matrix(dir_tab[i].cam));
    idle_sender(3);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        if (n == 150) hold_req <= 1'b1;
        // wait for the pipeline to run dry once
        if (n == 350) begin
          s_axis_tvalid <= 1'b0;
          while (matrix_q.size() != 0) @(posedge clk);
        end
        c = random_cam();
        send_item(c, view_matrix(c));
      end
      // some stretches run back to back
      idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    s_axis_tvalid <= 1'b0;

    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // ---------------- receiver ----------------

  // alternates between always ready, a fixed stall pattern and coin flips, after one long hold-off
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 700) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= (rx_cycle % 13) >= 4;
        default: m_axis_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  // ---------------- checker ----------------

  string fname[4] = '{"x", "y", "z", "shift"};
  string rname[3] = '{"right", "upward", "back"};

  always @(posedge clk) begin
    mat_t   want;
    int     off, wd;
    logic [31:0] a, e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", m_axis_tdata);
      end else begin
        want = matrix_q.pop_front();
        for (int r = 0; r < 3; r++)
          for (int f = 0; f < 4; f++) begin
            off = r * ROW_W + f * COMP_W;
            wd = (f == 3) ? WORD_W : COMP_W;
            a = (f == 3) ? m_axis_tdata[off +: WORD_W] : {14'd0, m_axis_tdata[off +: COMP_W]};
            e = (f == 3) ? want[off +: WORD_W] : {14'd0, want[off +: COMP_W]};
            if (a !== e) begin
              mismatches++;
              if (mismatches <= 10)
                $display("%s_%s mismatch: expected %h got %h (%0d bits)",
                         rname[r], fname[f], e, a, wd);
            end
          end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
